/* src/hfpr_pkg.sv */
// shared types, constants and helpers of the hex framed packet receiver
package hfpr_pkg;

  // field and state widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned CfgIdxW = 2;

  // default payload capacities
  localparam int unsigned SmallCapacityDef = 16;
  localparam int unsigned LargeCapacityDef = 256;

  // register reset values
  localparam logic [ByteW-1:0] EndCodeRst    = 8'd128;
  localparam logic [ByteW-1:0] LargeCodeARst = 8'd129;
  localparam logic [ByteW-1:0] LargeCodeBRst = 8'd130;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgEndCode   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLargeCodeA = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLargeCodeB = 2'd2;

  // result kinds
  localparam logic KindData = 1'b0;
  localparam logic KindEnd  = 1'b1;

  // hex character characters
  localparam logic [ByteW-1:0] AsciiUpperA = 8'd65;
  localparam logic [ByteW-1:0] UpperOffset = 8'd55;
  localparam logic [ByteW-1:0] DigitOffset = 8'd48;

  // one result item
  typedef struct packed {
    logic              kind;
    logic [ByteW-1:0]  data_byte;
    logic [ByteW-1:0]  byte_index;
    logic [ByteW-1:0]  command;
    logic [CountW-1:0] length;
    logic              large_res;
  } res_t;

  // wrapping nibble rule: letters from 'A' on, digits below
  function automatic logic [ByteW-1:0] nibble_of(input logic [ByteW-1:0] c);
    nibble_of = (c >= AsciiUpperA) ? (c - UpperOffset) : (c - DigitOffset);
  endfunction

endpackage

/* src/hfpr_frame.sv */
// framing state, configuration registers and per-byte decode
module hfpr_frame #(
  parameter int unsigned SMALL_CAPACITY = 16,
  parameter int unsigned LARGE_CAPACITY = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hfpr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hfpr_pkg::ByteW-1:0]    cfg_data_i,
  input  logic                          accept_i,
  input  logic [hfpr_pkg::ByteW-1:0]    rx_byte_i,
  output logic                          res_valid_o,
  output hfpr_pkg::res_t                res_o
);
  import hfpr_pkg::*;

  localparam logic [CountW-1:0] SmallCap = CountW'(SMALL_CAPACITY);
  localparam logic [CountW-1:0] LargeCap = CountW'(LARGE_CAPACITY);

  logic [ByteW-1:0]  end_code_q, large_code_a_q, large_code_b_q;
  logic [ByteW-1:0]  cur_command_q, cur_command_d;
  logic              packet_open_q, packet_open_d;
  logic              is_large_q, is_large_d;
  logic [CountW-1:0] byte_count_q, byte_count_d;
  logic [ByteW-1:0]  hex_hold_q, hex_hold_d;
  logic              hex_phase_q, hex_phase_d;

  logic              is_frame;
  logic [ByteW-1:0]  nib_hi, nib_lo, dec_val;
  logic [CountW-1:0] cap;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_code_q     <= EndCodeRst;
      large_code_a_q <= LargeCodeARst;
      large_code_b_q <= LargeCodeBRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgEndCode:    end_code_q     <= cfg_data_i;
        CfgLargeCodeA: large_code_a_q <= cfg_data_i;
        CfgLargeCodeB: large_code_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // hex pair decode
  assign is_frame = rx_byte_i[ByteW-1];
  assign nib_hi   = nibble_of(hex_hold_q);
  assign nib_lo   = nibble_of(rx_byte_i);
  assign dec_val  = {nib_hi[3:0], 4'b0000} | nib_lo;
  assign cap      = is_large_q ? LargeCap : SmallCap;

  // next state and result of one byte
  always_comb begin
    cur_command_d = cur_command_q;
    packet_open_d = packet_open_q;
    is_large_d    = is_large_q;
    byte_count_d  = byte_count_q;
    hex_hold_d    = hex_hold_q;
    hex_phase_d   = hex_phase_q;
    res_valid_o   = 1'b0;
    res_o.kind       = KindData;
    res_o.data_byte  = '0;
    res_o.byte_index = '0;
    res_o.command    = cur_command_q;
    res_o.length     = '0;
    res_o.large_res  = is_large_q;
    if (accept_i) begin
      if (is_frame) begin
        if (rx_byte_i == end_code_q) begin
          // close the packet and report its length
          packet_open_d = 1'b0;
          res_valid_o   = 1'b1;
          res_o.kind    = KindEnd;
          res_o.length  = byte_count_q;
        end else begin
          // open a new packet
          cur_command_d = rx_byte_i;
          is_large_d    = (rx_byte_i == large_code_a_q) || (rx_byte_i == large_code_b_q);
          byte_count_d  = '0;
          hex_phase_d   = 1'b0;
          hex_hold_d    = '0;
          packet_open_d = 1'b1;
        end
      end else if (packet_open_q) begin
        if (!hex_phase_q) begin
          hex_hold_d  = rx_byte_i;
          hex_phase_d = 1'b1;
        end else begin
          hex_phase_d = 1'b0;
          // keep the byte only below capacity
          if (byte_count_q < cap) begin
            res_valid_o      = 1'b1;
            res_o.data_byte  = dec_val;
            res_o.byte_index = byte_count_q[ByteW-1:0];
            byte_count_d     = byte_count_q + 1'b1;
          end
        end
      end
    end
  end

  // framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_command_q <= '0;
      packet_open_q <= 1'b0;
      is_large_q    <= 1'b0;
      byte_count_q  <= '0;
      hex_hold_q    <= '0;
      hex_phase_q   <= 1'b0;
    end else begin
      cur_command_q <= cur_command_d;
      packet_open_q <= packet_open_d;
      is_large_q    <= is_large_d;
      byte_count_q  <= byte_count_d;
      hex_hold_q    <= hex_hold_d;
      hex_phase_q   <= hex_phase_d;
    end
  end

endmodule

/* src/hex_framed_packet_receiver.sv */
// top level of the hex framed packet receiver: decode plus output skid buffer
//
// channel  direction  handshake               payload
// in       in         in_valid_i / in_stall_o  rx_byte_i
// out      out        out_valid_o / out_stall_i kind_o, data_byte_o, byte_index_o,
//                                             command_o, length_o, large_res_o
// cfg      in         cfg_we_i                cfg_idx_i, cfg_data_i
//
// one byte per cycle while in_stall_o is low; a result is registered in the
// result register, or in the one-entry skid register if the output stalls;
// they absorb a stall; in_stall_o rises only while both hold results
// reset clears framing state and loads the code registers with their defaults
module hex_framed_packet_receiver #(
  parameter int unsigned SMALL_CAPACITY = hfpr_pkg::SmallCapacityDef,
  parameter int unsigned LARGE_CAPACITY = hfpr_pkg::LargeCapacityDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hfpr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hfpr_pkg::ByteW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hfpr_pkg::ByteW-1:0]    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          kind_o,
  output logic [hfpr_pkg::ByteW-1:0]    data_byte_o,
  output logic [hfpr_pkg::ByteW-1:0]    byte_index_o,
  output logic [hfpr_pkg::ByteW-1:0]    command_o,
  output logic [hfpr_pkg::CountW-1:0]   length_o,
  output logic                          large_res_o
);
  import hfpr_pkg::*;

  logic   accept, res_valid, pop;
  res_t   res;
  res_t   out_q, skid_q;
  logic   out_valid_q, skid_valid_q;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign pop        = out_valid_q && !out_stall_i;

  hfpr_frame #(
    .SMALL_CAPACITY (SMALL_CAPACITY),
    .LARGE_CAPACITY (LARGE_CAPACITY)
  ) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) skid_valid_q <= 1'b0;
    end else if (res_valid) begin
      if (!out_valid_q || pop) out_valid_q <= 1'b1;
      else                     skid_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (res_valid) begin
      if (!out_valid_q || pop) out_q  <= res;
      else                     skid_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_q.kind;
  assign data_byte_o  = out_q.data_byte;
  assign byte_index_o = out_q.byte_index;
  assign command_o    = out_q.command;
  assign length_o     = out_q.length;
  assign large_res_o  = out_q.large_res;

endmodule
